// ===== design/round_robin_thread_scheduler_macros.svh =====
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RRTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rrts_pkg.sv =====
package rrts_pkg;

    localparam int SLOTS      = 32;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int ID_W       = 5;
    localparam int OP_W       = 3;
    localparam int SLEEP_W    = 32;
    localparam int TICK_W     = 10;
    localparam int TICK_RESET = 10;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_SLEEP   = 3'd1,
        OP_BLOCK   = 3'd2,
        OP_KILL    = 3'd3,
        OP_UNBLOCK = 3'd4,
        OP_START   = 3'd5
    } op_e;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_READY    = 3'd1,
        ST_RUNNING  = 3'd2,
        ST_SLEEPING = 3'd3,
        ST_BLOCKED  = 3'd4,
        ST_DONE     = 3'd5
    } slot_state_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_COUNT,
        S_SEEK_INIT,
        S_SEEK,
        S_REQ_READ,
        S_REQ_WRITE,
        S_SWITCH,
        S_CLAIM_WALK,
        S_CLAIM,
        S_EMIT
    } ctrl_state_e;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DISPATCH,
        DP_COUNT_STEP,
        DP_SEEK_INIT,
        DP_SEEK_STEP,
        DP_REQ_READ,
        DP_REQ_WRITE,
        DP_SWITCH,
        DP_CLAIM_STEP,
        DP_CLAIM,
        DP_EMIT
    } dp_cmd_e;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [ID_W-1:0]    thread_id;
        logic [SLEEP_W-1:0] sleep_ms;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0] running_thread;
        logic [ID_W-1:0] previous_thread;
        logic            switched;
        logic [ID_W-1:0] new_slot;
        logic            status;
    } result_t;

    typedef struct packed {
        dp_cmd_e cmd;
    } dp_ctrl_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            walk_done;
        logic            found;
    } dp_status_t;

    // slot index to the reported thread number (low bits)
    function automatic logic [ID_W-1:0] to_id(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[ID_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] from_id(input logic [ID_W-1:0] id);
        logic [31:0] wide;
        wide = 32'(id);
        return wide[IDX_W-1:0];
    endfunction

endpackage

// ===== design/round_robin_thread_scheduler.sv =====
// round robin thread scheduler with sleep timers
//
// items: drive item and raise start; the item transfers on a clock edge where
// start is high and busy is low. busy stays high until the result is out.
// results: one per item, shown on result for a single cycle with result_valid
// high; the receiver cannot stall, so it must take the transfer in that cycle.
// config: tick_step is written through cfg_valid/cfg_ready/cfg_data (ready is
// always high); write only while busy is low.
// flow per item: unblock and unused codes go from dispatch to the result;
// start walks down from the top slot to the first new or done slot and
// claims it (status set if there is none); tick/sleep/block/kill first
// sweep the timer countdown, then search round robin for a ready slot.
// the time per item is set by the slot table's single read port: the timer
// countdown sweeps every slot, then the round robin search walks from the
// running slot, one slot read per cycle each.
// reset: all slots new, the last slot running, tick_step 10; the slot table
// is not cleared, a per-slot written flag stands in for its reset value.
module round_robin_thread_scheduler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  rrts_pkg::item_t              item,
    output logic                         result_valid,
    output rrts_pkg::result_t            result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rrts_pkg::TICK_W-1:0]  cfg_data
);

    rrts_pkg::dp_ctrl_t   ctrl;
    rrts_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    rrts_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .ctrl   (ctrl)
    );

    rrts_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .item         (item),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

`include "round_robin_thread_scheduler_macros.svh"

    `RRTS_ASSERT_NEXT(a_strobe_single, clk, rst_n, result_valid, !result_valid, "result strobe longer than one cycle")
    `RRTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy, "not busy after item transfer")
    `RRTS_ASSERT_IMPLY(a_idle_at_result, clk, rst_n, result_valid, !busy, "result shown while still busy")
    `RRTS_ASSERT_IMPLY(a_fail_no_slot, clk, rst_n, result_valid && result.status, result.new_slot == '0, "failed start reports a slot")

endmodule

// ===== design/rrts_ctrl.sv =====
module rrts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rrts_pkg::dp_status_t status,
    output rrts_pkg::dp_ctrl_t   ctrl
);

    rrts_pkg::ctrl_state_e state_reg;
    rrts_pkg::ctrl_state_e state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl.cmd   = rrts_pkg::DP_NOP;
        busy       = 1'b1;
        case (state_reg)
            rrts_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.cmd   = rrts_pkg::DP_LOAD;
                    state_next = rrts_pkg::S_DISPATCH;
                end
            end
            rrts_pkg::S_DISPATCH:
            begin
                ctrl.cmd = rrts_pkg::DP_DISPATCH;
                case (status.op)
                    rrts_pkg::OP_TICK,
                    rrts_pkg::OP_SLEEP,
                    rrts_pkg::OP_BLOCK,
                    rrts_pkg::OP_KILL:  state_next = rrts_pkg::S_COUNT;
                    rrts_pkg::OP_START: state_next = rrts_pkg::S_CLAIM_WALK;
                    default:            state_next = rrts_pkg::S_EMIT;
                endcase
            end
            rrts_pkg::S_COUNT:
            begin
                ctrl.cmd = rrts_pkg::DP_COUNT_STEP;
                if (status.walk_done)
                begin
                    state_next = rrts_pkg::S_SEEK_INIT;
                end
            end
            rrts_pkg::S_SEEK_INIT:
            begin
                ctrl.cmd   = rrts_pkg::DP_SEEK_INIT;
                state_next = rrts_pkg::S_SEEK;
            end
            rrts_pkg::S_SEEK:
            begin
                ctrl.cmd = rrts_pkg::DP_SEEK_STEP;
                if (status.found)
                begin
                    state_next = rrts_pkg::S_REQ_READ;
                end
                else if (status.walk_done)
                begin
                    state_next = rrts_pkg::S_EMIT;
                end
            end
            rrts_pkg::S_REQ_READ:
            begin
                ctrl.cmd   = rrts_pkg::DP_REQ_READ;
                state_next = rrts_pkg::S_REQ_WRITE;
            end
            rrts_pkg::S_REQ_WRITE:
            begin
                ctrl.cmd   = rrts_pkg::DP_REQ_WRITE;
                state_next = rrts_pkg::S_SWITCH;
            end
            rrts_pkg::S_SWITCH:
            begin
                ctrl.cmd   = rrts_pkg::DP_SWITCH;
                state_next = rrts_pkg::S_EMIT;
            end
            rrts_pkg::S_CLAIM_WALK:
            begin
                ctrl.cmd = rrts_pkg::DP_CLAIM_STEP;
                if (status.found || status.walk_done)
                begin
                    state_next = rrts_pkg::S_CLAIM;
                end
            end
            rrts_pkg::S_CLAIM:
            begin
                ctrl.cmd   = rrts_pkg::DP_CLAIM;
                state_next = rrts_pkg::S_EMIT;
            end
            rrts_pkg::S_EMIT:
            begin
                ctrl.cmd   = rrts_pkg::DP_EMIT;
                state_next = rrts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rrts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/rrts_datapath.sv =====
module rrts_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rrts_pkg::dp_ctrl_t           ctrl,
    output rrts_pkg::dp_status_t         status,
    input  rrts_pkg::item_t              item,
    input  logic                         cfg_we,
    input  logic [rrts_pkg::TICK_W-1:0]  cfg_data,
    output logic                         result_valid,
    output rrts_pkg::result_t            result
);

    localparam logic [rrts_pkg::IDX_W-1:0] LAST_IDX = rrts_pkg::IDX_W'(rrts_pkg::SLOTS - 1);
    localparam logic [rrts_pkg::CNT_W-1:0] CNT_END  = rrts_pkg::CNT_W'(rrts_pkg::SLOTS);

    // slot tables
    rrts_pkg::slot_state_e            state_mem [rrts_pkg::SLOTS];
    logic [rrts_pkg::SLEEP_W-1:0]     sleep_mem [rrts_pkg::SLOTS];
    logic [rrts_pkg::SLOTS-1:0]       written_reg;

    logic                             rd_en;
    logic [rrts_pkg::IDX_W-1:0]       rd_addr;
    logic                             wr_en;
    logic                             sleep_we;
    logic [rrts_pkg::IDX_W-1:0]       wr_addr;
    rrts_pkg::slot_state_e            wr_state;
    logic [rrts_pkg::SLEEP_W-1:0]     wr_sleep;

    rrts_pkg::slot_state_e            rd_state_reg;
    logic [rrts_pkg::SLEEP_W-1:0]     rd_sleep_reg;
    logic                             rd_written_reg;
    logic [rrts_pkg::IDX_W-1:0]       rd_addr_reg;
    rrts_pkg::slot_state_e            eff_state;

    logic [rrts_pkg::IDX_W-1:0]       run_reg, run_next;
    logic [rrts_pkg::TICK_W-1:0]      tick_reg, tick_next;
    logic [rrts_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                             pend_reg, pend_next;
    logic                             found_reg, found_next;
    logic                             result_valid_reg, result_valid_next;

    logic [rrts_pkg::OP_W-1:0]        op_reg, op_next;
    logic [rrts_pkg::ID_W-1:0]        tid_reg, tid_next;
    logic [rrts_pkg::SLEEP_W-1:0]     ms_reg, ms_next;
    logic [rrts_pkg::IDX_W-1:0]       prev_reg, prev_next;
    logic [rrts_pkg::IDX_W-1:0]       claimed_reg, claimed_next;
    logic                             status_reg, status_next;
    logic [rrts_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [rrts_pkg::IDX_W-1:0]       found_idx_reg, found_idx_next;
    rrts_pkg::result_t                result_reg, result_next;

    logic                             issue;
    logic                             walk_hit;
    logic                             tid_ok;

    // entries never written read as their reset state
    assign eff_state = rd_written_reg ? rd_state_reg
                     : ((rd_addr_reg == LAST_IDX) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_NEW);

    assign issue  = (cnt_reg != CNT_END) && !found_reg;
    assign tid_ok = 32'(tid_reg) < rrts_pkg::SLOTS;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[wr_addr] <= wr_state;
        end
        if (sleep_we)
        begin
            sleep_mem[wr_addr] <= wr_sleep;
        end
        if (rd_en)
        begin
            rd_state_reg   <= state_mem[rd_addr];
            rd_sleep_reg   <= sleep_mem[rd_addr];
            rd_written_reg <= written_reg[rd_addr];
            rd_addr_reg    <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg      <= '0;
            run_reg          <= LAST_IDX;
            tick_reg         <= rrts_pkg::TICK_W'(rrts_pkg::TICK_RESET);
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            run_reg          <= run_next;
            tick_reg         <= tick_next;
            cnt_reg          <= cnt_next;
            pend_reg         <= pend_next;
            found_reg        <= found_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        tid_reg       <= tid_next;
        ms_reg        <= ms_next;
        prev_reg      <= prev_next;
        claimed_reg   <= claimed_next;
        status_reg    <= status_next;
        idx_reg       <= idx_next;
        found_idx_reg <= found_idx_next;
        result_reg    <= result_next;
    end

    always_comb
    begin
        rd_en             = 1'b0;
        rd_addr           = idx_reg;
        wr_en             = 1'b0;
        sleep_we          = 1'b0;
        wr_addr           = rd_addr_reg;
        wr_state          = rrts_pkg::ST_READY;
        wr_sleep          = '0;
        walk_hit          = 1'b0;
        run_next          = run_reg;
        tick_next         = cfg_we ? cfg_data : tick_reg;
        cnt_next          = cnt_reg;
        pend_next         = pend_reg;
        found_next        = found_reg;
        result_valid_next = 1'b0;
        op_next           = op_reg;
        tid_next          = tid_reg;
        ms_next           = ms_reg;
        prev_next         = prev_reg;
        claimed_next      = claimed_reg;
        status_next       = status_reg;
        idx_next          = idx_reg;
        found_idx_next    = found_idx_reg;
        result_next       = result_reg;

        case (ctrl.cmd)
            rrts_pkg::DP_LOAD:
            begin
                op_next      = item.operation;
                tid_next     = item.thread_id;
                ms_next      = item.sleep_ms;
                prev_next    = run_reg;
                claimed_next = '0;
                status_next  = 1'b0;
            end
            rrts_pkg::DP_DISPATCH:
            begin
                cnt_next   = '0;
                pend_next  = 1'b0;
                found_next = 1'b0;
                idx_next   = LAST_IDX;
                wr_addr    = run_reg;
                case (op_reg)
                    rrts_pkg::OP_SLEEP:
                    begin
                        wr_en    = 1'b1;
                        wr_state = rrts_pkg::ST_SLEEPING;
                        sleep_we = 1'b1;
                        wr_sleep = ms_reg;
                    end
                    rrts_pkg::OP_BLOCK:
                    begin
                        wr_en    = 1'b1;
                        wr_state = rrts_pkg::ST_BLOCKED;
                    end
                    rrts_pkg::OP_KILL:
                    begin
                        wr_en    = 1'b1;
                        wr_state = rrts_pkg::ST_DONE;
                    end
                    rrts_pkg::OP_UNBLOCK:
                    begin
                        wr_en    = tid_ok;
                        wr_addr  = rrts_pkg::from_id(tid_reg);
                        wr_state = rrts_pkg::ST_READY;
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            rrts_pkg::DP_COUNT_STEP:
            begin
                // read slot n while writing back slot n-1
                if (cnt_reg != CNT_END)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = cnt_reg[rrts_pkg::IDX_W-1:0];
                    cnt_next = cnt_reg + rrts_pkg::CNT_W'(1);
                end
                pend_next = (cnt_reg != CNT_END);
                if (pend_reg && (eff_state == rrts_pkg::ST_SLEEPING))
                begin
                    wr_en    = 1'b1;
                    sleep_we = 1'b1;
                    if (rd_sleep_reg <= rrts_pkg::SLEEP_W'(tick_reg))
                    begin
                        wr_sleep = '0;
                        wr_state = rrts_pkg::ST_READY;
                    end
                    else
                    begin
                        wr_sleep = rd_sleep_reg - rrts_pkg::SLEEP_W'(tick_reg);
                        wr_state = rrts_pkg::ST_SLEEPING;
                    end
                end
            end
            rrts_pkg::DP_SEEK_INIT:
            begin
                idx_next   = run_reg;
                cnt_next   = '0;
                pend_next  = 1'b0;
                found_next = 1'b0;
            end
            rrts_pkg::DP_SEEK_STEP:
            begin
                if (issue)
                begin
                    rd_en    = 1'b1;
                    idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + rrts_pkg::IDX_W'(1);
                    cnt_next = cnt_reg + rrts_pkg::CNT_W'(1);
                end
                pend_next = issue;
                walk_hit  = pend_reg && !found_reg && (eff_state == rrts_pkg::ST_READY);
                if (walk_hit)
                begin
                    found_next     = 1'b1;
                    found_idx_next = rd_addr_reg;
                end
            end
            rrts_pkg::DP_REQ_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = run_reg;
            end
            rrts_pkg::DP_REQ_WRITE:
            begin
                // old slot goes back to ready only if it was still running
                wr_en    = (eff_state == rrts_pkg::ST_RUNNING);
                wr_addr  = run_reg;
                wr_state = rrts_pkg::ST_READY;
            end
            rrts_pkg::DP_SWITCH:
            begin
                wr_en    = 1'b1;
                wr_addr  = found_idx_reg;
                wr_state = rrts_pkg::ST_RUNNING;
                run_next = found_idx_reg;
            end
            rrts_pkg::DP_CLAIM_STEP:
            begin
                // walk down from the highest slot
                if (issue)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg - rrts_pkg::IDX_W'(1);
                    cnt_next = cnt_reg + rrts_pkg::CNT_W'(1);
                end
                pend_next = issue;
                walk_hit  = pend_reg && !found_reg
                         && ((eff_state == rrts_pkg::ST_NEW) || (eff_state == rrts_pkg::ST_DONE));
                if (walk_hit)
                begin
                    found_next     = 1'b1;
                    found_idx_next = rd_addr_reg;
                end
            end
            rrts_pkg::DP_CLAIM:
            begin
                if (found_reg)
                begin
                    wr_en        = 1'b1;
                    wr_addr      = found_idx_reg;
                    wr_state     = rrts_pkg::ST_READY;
                    claimed_next = found_idx_reg;
                end
                else
                begin
                    status_next = 1'b1;
                end
            end
            rrts_pkg::DP_EMIT:
            begin
                result_valid_next           = 1'b1;
                result_next.running_thread  = rrts_pkg::to_id(run_reg);
                result_next.previous_thread = rrts_pkg::to_id(prev_reg);
                result_next.switched        = (run_reg != prev_reg);
                result_next.new_slot        = rrts_pkg::to_id(claimed_reg);
                result_next.status          = status_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign status.op        = op_reg;
    assign status.walk_done = (cnt_reg == CNT_END) && !pend_reg;
    assign status.found     = found_reg;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rrts_pkg::*;

    // operation codes the block must ignore
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 16;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    item_t             item;
    logic              result_valid;
    result_t           result;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [TICK_W-1:0] cfg_data;

    int unsigned error_count    = 0;
    int unsigned sender_gap_pct = 0;

    // mirror of the slot table, running slot and tick step
    slot_state_e       thread_st [SLOTS];
    logic [31:0]       sleep_cnt [SLOTS];
    int unsigned       run_slot;
    logic [TICK_W-1:0] tick_ms;

    result_t expected_results [$];

    round_robin_thread_scheduler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void mirror_reset();
        for (int i = 0; i < SLOTS; i++)
        begin
            thread_st[i] = ST_NEW;
            sleep_cnt[i] = '0;
        end
        run_slot            = SLOTS - 1;
        thread_st[SLOTS-1]  = ST_RUNNING;
        tick_ms             = TICK_W'(TICK_RESET);
    endfunction

    function automatic void reschedule_mirror();
        int unsigned cand;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (thread_st[i] == ST_SLEEPING)
            begin
                if (sleep_cnt[i] <= 32'(tick_ms))
                begin
                    sleep_cnt[i] = '0;
                    thread_st[i] = ST_READY;
                end
                else
                begin
                    sleep_cnt[i] = sleep_cnt[i] - 32'(tick_ms);
                end
            end
        end
        // search starts at the running slot itself
        cand = run_slot;
        while (thread_st[cand] != ST_READY)
        begin
            cand = (cand + 1) % SLOTS;
            if (cand == run_slot)
                break;
        end
        if (thread_st[cand] == ST_READY)
        begin
            if (thread_st[run_slot] == ST_RUNNING)
                thread_st[run_slot] = ST_READY;
            run_slot         = cand;
            thread_st[cand]  = ST_RUNNING;
        end
    endfunction

    function automatic result_t predict_schedule(item_t it);
        result_t     r;
        int unsigned prev;
        int unsigned claimed;
        logic        no_free;
        int          slot;
        prev    = run_slot;
        claimed = 0;
        no_free = 1'b0;
        case (it.operation)
            OP_TICK:
            begin
                reschedule_mirror();
            end
            OP_SLEEP:
            begin
                sleep_cnt[run_slot] = it.sleep_ms;
                thread_st[run_slot] = ST_SLEEPING;
                reschedule_mirror();
            end
            OP_BLOCK:
            begin
                thread_st[run_slot] = ST_BLOCKED;
                reschedule_mirror();
            end
            OP_KILL:
            begin
                thread_st[run_slot] = ST_DONE;
                reschedule_mirror();
            end
            OP_UNBLOCK:
            begin
                if (int'(it.thread_id) < SLOTS)
                    thread_st[it.thread_id] = ST_READY;
            end
            OP_START:
            begin
                slot = SLOTS - 1;
                while (slot >= 0 && thread_st[slot] != ST_NEW && thread_st[slot] != ST_DONE)
                    slot--;
                if (slot >= 0)
                begin
                    thread_st[slot] = ST_READY;
                    claimed         = slot;
                end
                else
                begin
                    no_free = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.running_thread  = ID_W'(run_slot);
        r.previous_thread = ID_W'(prev);
        r.switched        = (run_slot != prev);
        r.new_slot        = ID_W'(claimed);
        r.status          = no_free;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected: %p", result);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("running_thread", 32'(want.running_thread),
                            32'(result.running_thread));
                check_field("previous_thread", 32'(want.previous_thread),
                            32'(result.previous_thread));
                check_field("switched", 32'(want.switched), 32'(result.switched));
                check_field("new_slot", 32'(want.new_slot), 32'(result.new_slot));
                check_field("status", 32'(want.status), 32'(result.status));
            end
        end
    end

    task automatic issue(logic [OP_W-1:0] op, logic [ID_W-1:0] tid, logic [SLEEP_W-1:0] ms);
        item_t it;
        it.operation = op;
        it.thread_id = tid;
        it.sleep_ms  = ms;
        if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, DRAIN_CYCLES)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        expected_results.push_back(predict_schedule(it));
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_tick(logic [TICK_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tick_ms    = v;
    endtask

    task automatic issue_random();
        int unsigned        pick;
        logic [ID_W-1:0]    tid;
        logic [SLEEP_W-1:0] ms;
        int                 parked [$];
        pick = $urandom_range(99);
        tid  = ID_W'($urandom());
        case ($urandom_range(9))
            0:       ms = $urandom();
            1:       ms = '1;
            2:       ms = '0;
            default: ms = $urandom_range(0, 6 * int'(tick_ms) + 3);
        endcase
        if (pick < 30)
            issue(OP_TICK, tid, ms);
        else if (pick < 45)
            issue(OP_SLEEP, tid, ms);
        else if (pick < 55)
            issue(OP_BLOCK, tid, ms);
        else if (pick < 63)
            issue(OP_KILL, tid, ms);
        else if (pick < 78)
        begin
            // mostly wake a slot that is actually parked
            for (int i = 0; i < SLOTS; i++)
                if (thread_st[i] == ST_BLOCKED || thread_st[i] == ST_SLEEPING)
                    parked.push_back(i);
            if (parked.size() != 0 && $urandom_range(9) < 7)
                tid = ID_W'(parked[$urandom_range(parked.size() - 1)]);
            issue(OP_UNBLOCK, tid, ms);
        end
        else if (pick < 96)
            issue(OP_START, tid, ms);
        else
            issue(pick[0] ? OP_RSVD_6 : OP_RSVD_7, tid, ms);
    endtask

    task automatic test_directed_ops();
        issue(OP_TICK, '0, '0);               // nothing ready yet
        issue(OP_RSVD_6, '1, '1);
        issue(OP_RSVD_7, '1, '1);
        issue(OP_UNBLOCK, 5'd31, '0);         // running slot made ready
        issue(OP_TICK, '0, '0);
        issue(OP_START, '0, '0);
        issue(OP_START, '1, '1);
        issue(OP_TICK, '0, '0);
        issue(OP_SLEEP, '0, 32'd0);           // wakes in the same reschedule
        issue(OP_SLEEP, '0, 32'd10);          // count equal to the step
        issue(OP_SLEEP, '0, 32'd11);
        issue(OP_TICK, '0, '0);
        issue(OP_SLEEP, '0, 32'hFFFF_FFFF);
        issue(OP_BLOCK, '0, '0);
        issue(OP_UNBLOCK, 5'd31, '0);
        issue(OP_KILL, '0, '0);
        issue(OP_START, '0, '0);
        issue(OP_UNBLOCK, 5'd0, '0);
        issue(OP_UNBLOCK, 5'b10101, 32'hAAAA_AAAA);
        issue(OP_UNBLOCK, 5'b01010, 32'h5555_5555);
        issue(OP_BLOCK, '0, '0);
        issue(OP_BLOCK, '0, '0);
        issue(OP_TICK, '0, '0);
        wait_idle();
    endtask

    task automatic test_tick_step_extremes();
        write_tick('0);
        issue(OP_SLEEP, '0, 32'd5);           // never counts down
        issue(OP_SLEEP, '0, 32'd0);
        issue(OP_TICK, '0, '0);
        issue(OP_TICK, '0, '0);
        write_tick('1);
        issue(OP_SLEEP, '0, 32'd1023);
        issue(OP_SLEEP, '0, 32'd1024);
        issue(OP_TICK, '0, '0);
        issue(OP_TICK, '0, '0);
        write_tick(TICK_W'(1));
        issue(OP_SLEEP, '0, 32'd2);
        issue(OP_TICK, '0, '0);
        issue(OP_TICK, '0, '0);
        write_tick(TICK_W'(1000));
        issue(OP_SLEEP, '0, 32'd999);
        issue(OP_TICK, '0, '0);
    endtask

    task automatic test_slot_exhaustion();
        int free_slots;
        for (int round = 0; round < 2; round++)
        begin
            do
            begin
                free_slots = 0;
                for (int i = 0; i < SLOTS; i++)
                    if (thread_st[i] == ST_NEW || thread_st[i] == ST_DONE)
                        free_slots++;
                issue(OP_START, ID_W'($urandom()), $urandom());
            end
            while (free_slots != 0);
            issue(OP_START, '0, '0);
            issue(OP_KILL, '0, '0);
            issue(OP_TICK, '0, '0);
            issue(OP_KILL, '0, '0);
        end
    endtask

    task automatic test_random_traffic(int unsigned gap_pct, int unsigned n_items);
        logic [TICK_W-1:0] step;
        for (int seg = 0; seg < 3; seg++)
        begin
            case ($urandom_range(5))
                0:       step = '0;
                1:       step = TICK_W'(1);
                2:       step = TICK_W'(1000);
                3:       step = '1;
                4:       step = TICK_W'(TICK_RESET);
                default: step = TICK_W'($urandom_range(1, 1000));
            endcase
            write_tick(step);
            sender_gap_pct = gap_pct;
            repeat (n_items / 3) issue_random();
            sender_gap_pct = 0;
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        mirror_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_ops();
        test_tick_step_extremes();
        test_slot_exhaustion();
        test_random_traffic(8, 300);
        test_random_traffic(57, 300);
        test_random_traffic(0, 300);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("round_robin_thread_scheduler regression: pass");
        else
            $display("round_robin_thread_scheduler regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("round_robin_thread_scheduler regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/rrts_pkg.sv
design/rrts_ctrl.sv
design/rrts_datapath.sv
design/round_robin_thread_scheduler.sv
test/tb_top.sv
